// ===== design/set_assoc_lru_cache_sim_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache
// Concurrent checks that compile out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH

`ifndef SYNTH
`define SACL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SACL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SACL_ASSERT_IMP(lbl, ante, cons, msg)
`define SACL_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/sacl_pkg.sv =====
// ---------------------------------------------------------------------------
// Set-associative LRU cache package
// Payload types, operation, outcome and register codes.
// ---------------------------------------------------------------------------
package sacl_pkg;

  localparam int AddrW    = 64;
  localparam int TotalW   = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 6;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WAYS        = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] address;
  } in_t;

  typedef struct packed {
    logic [1:0]        outcome;
    logic              last_of_run;
    logic [TotalW-1:0] hit_total;
    logic [TotalW-1:0] miss_total;
    logic [TotalW-1:0] eviction_total;
  } out_t;

endpackage

// ===== design/set_assoc_lru_cache_sim.sv =====
// ---------------------------------------------------------------------------
// Set-associative LRU cache simulator
// Classifies accesses into set and tag, queues them, and runs each access
// against the line store with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Channel  Direction  Signals
// in       input      in_valid_i, in_ready_o, in_data_i (operation, address)
// out      output     out_valid_o, out_ready_i, out_data_o (outcome, totals)
// cfg      input      cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// Each access runs through the back end in order: set read, tag and stamp compare,
// line update with result; a modify adds a further step for its second result.
// The next access reads its set only after this update, so accesses never overlap.
// After reset, the valid bits of all 2^MAX_SET_BITS sets are cleared; in_ready_o is low meanwhile.
// A stalled result holds the back end in its update or second step; the queue
// keeps taking up to two accesses meanwhile.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sacl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sacl_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sacl_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sacl_pkg::out_t                out_data_o
);

  import sacl_pkg::*;

  localparam int SetW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int JobW = SetW + AddrW + 1;

  logic            push, q_full, q_valid, pop, accept_en;
  logic [JobW-1:0] push_data, q_data;
  logic [WAYS-1:0] way_en;

  sacl_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS),
    .SetW         (SetW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .accept_en_i (accept_en),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data),
    .way_en_o    (way_en)
  );

  sacl_fifo #(
    .DW    (JobW),
    .DEPTH (2)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (pop)
  );

  sacl_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS),
    .SetW         (SetW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .way_en_i    (way_en),
    .accept_en_o (accept_en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/sacl_fifo.sv =====
// ---------------------------------------------------------------------------
// Access queue
// Small FIFO between the classifying front end and the cache back end.
// ---------------------------------------------------------------------------
module sacl_fifo #(
  parameter int DW    = 72,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  output logic          valid_o,
  output logic [DW-1:0] data_o,
  input  logic          pop_i
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DW-1:0]   entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/sacl_front.sv =====
// ---------------------------------------------------------------------------
// Cache front end
// Holds configuration, splits each address into set and tag, queues the job.
// ---------------------------------------------------------------------------
module sacl_front #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int SetW         = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sacl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sacl_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sacl_pkg::in_t                   in_data_i,
  input  logic                            accept_en_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output logic [SetW+sacl_pkg::AddrW:0]   push_data_o,
  output logic [WAYS-1:0]                 way_en_o
);

  import sacl_pkg::*;

  logic [2:0]       set_bits_q;
  logic [5:0]       off_bits_q;
  logic [3:0]       ways_q;
  logic [2:0]       set_bits_eff;
  logic [31:0]      ways_lim;
  logic [AddrW-1:0] shifted;
  logic [AddrW-1:0] tag;
  logic [SetW-1:0]  set_mask;
  logic [SetW-1:0]  set_idx;
  logic             twice;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= '0;
      off_bits_q <= '0;
      ways_q     <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SET_BITS:    set_bits_q <= cfg_data_i[2:0];
        CFG_OFFSET_BITS: off_bits_q <= cfg_data_i;
        CFG_WAYS:        ways_q     <= cfg_data_i[3:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    if ({29'd0, set_bits_q} > 32'(MAX_SET_BITS)) begin
      set_bits_eff = 3'(MAX_SET_BITS);
    end else begin
      set_bits_eff = set_bits_q;
    end
    for (int k = 0; k < SetW; k++) begin
      set_mask[k] = (32'(k) < {29'd0, set_bits_eff});
    end
    if (ways_q == '0) begin
      ways_lim = 32'd1;
    end else if ({28'd0, ways_q} > 32'(WAYS)) begin
      ways_lim = 32'(WAYS);
    end else begin
      ways_lim = {28'd0, ways_q};
    end
    for (int w = 0; w < WAYS; w++) begin
      way_en_o[w] = (32'(w) < ways_lim);
    end
  end

  assign shifted = in_data_i.address >> off_bits_q;
  assign tag     = shifted >> set_bits_eff;
  assign set_idx = shifted[SetW-1:0] & set_mask;
  assign twice   = (in_data_i.operation == OP_MODIFY);

  assign in_ready_o  = accept_en_i && !q_full_i;
  assign push_o      = in_valid_i && in_ready_o;
  assign push_data_o = {twice, tag, set_idx};

endmodule

// ===== design/sacl_back.sv =====
// ---------------------------------------------------------------------------
// Cache back end
// Reads a set, matches tags, picks the LRU victim, updates lines and totals.
// ---------------------------------------------------------------------------
`include "set_assoc_lru_cache_sim_defines.svh"

module sacl_back #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int SetW         = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  logic [SetW+sacl_pkg::AddrW:0] q_data_i,
  output logic                          pop_o,
  input  logic [WAYS-1:0]               way_en_i,
  output logic                          accept_en_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sacl_pkg::out_t                out_data_o
);

  import sacl_pkg::*;

  localparam int Sets = 1 << MAX_SET_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CMP,
    ST_DECIDE,
    ST_SECOND
  } state_e;

  function automatic logic [TotalW-1:0] sat_inc(input logic [TotalW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  logic [WAYS-1:0]                valid_mem [Sets];
  logic [WAYS-1:0][AddrW-1:0]     tag_mem   [Sets];
  logic [WAYS-1:0][AddrW-1:0]     stamp_mem [Sets];

  state_e                         state_q;
  logic [SetW-1:0]                clr_q;
  logic [SetW-1:0]                job_set_q;
  logic [AddrW-1:0]               job_tag_q;
  logic                           job_twice_q;
  logic [AddrW-1:0]               use_cnt_q;
  logic [TotalW-1:0]              hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic                           out_valid_q;
  out_t                           out_q;

  logic [WAYS-1:0]                vrow_q;
  logic [WAYS-1:0][AddrW-1:0]     trow_q, srow_q;
  logic [WAYS-1:0]                hit_q, inval_q;
  logic [WAYS-1:0][WAYS-1:0]      lt_q;

  logic [WAYS-1:0]                hit_vec, inval_vec;
  logic [WAYS-1:0][WAYS-1:0]      lt;
  logic [WAYS-1:0]                victim_oh, hit_first, inval_first, place_oh;
  logic                           any_hit, any_empty, slot_free;
  logic                           res_load;
  logic [1:0]                     outcome;
  logic [TotalW-1:0]              hit_after, miss_after, evict_after;
  logic [AddrW-1:0]               stamp_val;
  logic [WAYS-1:0]                new_v;
  logic [WAYS-1:0][AddrW-1:0]     new_t, new_s;
  logic                           v_we, ts_we;
  logic [SetW-1:0]                v_addr;
  logic [WAYS-1:0]                v_wdata;

  assign accept_en_o = (state_q != ST_CLEAR);
  assign pop_o       = (state_q == ST_IDLE) && q_valid_i;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign res_load    = ((state_q == ST_DECIDE) || (state_q == ST_SECOND)) && slot_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]   = way_en_i[w] && vrow_q[w] && (trow_q[w] == job_tag_q);
      inval_vec[w] = way_en_i[w] && !vrow_q[w];
    end
    for (int a = 0; a < WAYS; a++) begin
      for (int b = 0; b < WAYS; b++) begin
        lt[a][b] = (a > b) && (srow_q[a] < srow_q[b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CMP) begin
      hit_q   <= hit_vec;
      inval_q <= inval_vec;
      lt_q    <= lt;
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      victim_oh[i] = way_en_i[i];
      for (int j = 0; j < WAYS; j++) begin
        if (j < i && way_en_i[j] && !lt_q[i][j]) begin
          victim_oh[i] = 1'b0;
        end
        if (j > i && way_en_i[j] && lt_q[j][i]) begin
          victim_oh[i] = 1'b0;
        end
      end
    end
    any_hit     = |hit_q;
    any_empty   = |inval_q;
    hit_first   = hit_q & (~hit_q + 1'b1);
    inval_first = inval_q & (~inval_q + 1'b1);
    if (any_hit) begin
      place_oh = hit_first;
      outcome  = OUT_HIT;
    end else if (any_empty) begin
      place_oh = inval_first;
      outcome  = OUT_MISS;
    end else begin
      place_oh = victim_oh;
      outcome  = OUT_EVICT;
    end
    hit_after   = any_hit ? sat_inc(hit_cnt_q) : hit_cnt_q;
    miss_after  = any_hit ? miss_cnt_q : sat_inc(miss_cnt_q);
    evict_after = (outcome == OUT_EVICT) ? sat_inc(evict_cnt_q) : evict_cnt_q;
    stamp_val   = job_twice_q ? use_cnt_q + 1'b1 : use_cnt_q;
    new_v       = vrow_q | place_oh;
    for (int w = 0; w < WAYS; w++) begin
      new_t[w] = (place_oh[w] && !any_hit) ? job_tag_q : trow_q[w];
      new_s[w] = place_oh[w] ? stamp_val : srow_q[w];
    end
    ts_we   = (state_q == ST_DECIDE) && slot_free;
    v_we    = (state_q == ST_CLEAR) || ts_we;
    v_addr  = (state_q == ST_CLEAR) ? clr_q : job_set_q;
    v_wdata = (state_q == ST_CLEAR) ? '0 : new_v;
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      valid_mem[v_addr] <= v_wdata;
    end
    if (ts_we) begin
      tag_mem[job_set_q]   <= new_t;
      stamp_mem[job_set_q] <= new_s;
    end
    if (pop_o) begin
      vrow_q <= valid_mem[q_data_i[SetW-1:0]];
      trow_q <= tag_mem[q_data_i[SetW-1:0]];
      srow_q <= stamp_mem[q_data_i[SetW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      job_set_q   <= '0;
      job_tag_q   <= '0;
      job_twice_q <= 1'b0;
      use_cnt_q   <= AddrW'(1);
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (clr_q == SetW'(Sets - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (pop_o) begin
            job_set_q   <= q_data_i[SetW-1:0];
            job_tag_q   <= q_data_i[SetW+AddrW-1:SetW];
            job_twice_q <= q_data_i[SetW+AddrW];
            state_q     <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (slot_free) begin
            hit_cnt_q   <= hit_after;
            miss_cnt_q  <= miss_after;
            evict_cnt_q <= evict_after;
            use_cnt_q   <= stamp_val + 1'b1;
            out_q       <= '{outcome:        outcome,
                             last_of_run:    !job_twice_q,
                             hit_total:      hit_after,
                             miss_total:     miss_after,
                             eviction_total: evict_after};
            state_q     <= job_twice_q ? ST_SECOND : ST_IDLE;
          end
        end
        ST_SECOND: begin
          if (slot_free) begin
            hit_cnt_q   <= sat_inc(hit_cnt_q);
            out_q       <= '{outcome:        OUT_HIT,
                             last_of_run:    1'b1,
                             hit_total:      sat_inc(hit_cnt_q),
                             miss_total:     miss_cnt_q,
                             eviction_total: evict_cnt_q};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `SACL_ASSERT_IMP(a_victim_onehot, (state_q == ST_DECIDE) && !any_hit && !any_empty, $onehot(victim_oh), "eviction without a single victim way")
  `SACL_ASSERT_IMP(a_evict_le_miss, 1'b1, evict_cnt_q <= miss_cnt_q, "eviction total exceeds miss total")
  `SACL_ASSERT_NXT(a_second_hits, (state_q == ST_SECOND) && slot_free, out_valid_q && (out_q.outcome == OUT_HIT) && out_q.last_of_run, "second access of modify did not hit")
  `SACL_ASSERT_NXT(a_hit_count, (state_q == ST_DECIDE) && slot_free && any_hit && (hit_cnt_q != '1), hit_cnt_q == $past(hit_cnt_q) + 32'd1, "hit total did not advance on a hit")

endmodule

// ===== tb/set_assoc_lru_cache_sim_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the set-associative LRU cache simulator
// Sends load, store and modify accesses through the input channel and
// programs the split and way registers between phases. The line store, the
// use stamps and the totals are tracked alongside the design. Every result
// is compared field by field with the oldest predicted one. Directed
// sequences cover the reset settings, clamped registers, the wide split and
// LRU victim choice. Random phases reuse a small tag pool so that hits and
// evictions are frequent; all phases but one stall both channels at random.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_sim_tb;
  import sacl_pkg::*;

  localparam int MaxSetBits = 6;
  localparam int Ways       = 8;
  localparam int LineCount  = (1 << MaxSetBits) * Ways;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 250;
  localparam int TagPoolMax = 12;

  localparam logic [1:0]         OpReserved = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused  = 2'd3;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;

  logic        line_valid [LineCount];
  logic [63:0] line_tag   [LineCount];
  logic [63:0] line_stamp [LineCount];
  logic [63:0] use_stamp;
  logic [31:0] hits_seen;
  logic [31:0] misses_seen;
  logic [31:0] evictions_seen;
  logic [2:0]  set_bits_reg;
  logic [5:0]  offset_bits_reg;
  logic [3:0]  ways_reg;

  out_t expected_results [$];
  out_t oldest_expected;
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  logic steady         = 1'b0;

  set_assoc_lru_cache_sim #(
    .MAX_SET_BITS(MaxSetBits),
    .WAYS        (Ways)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int eff_set_bits();
    return (set_bits_reg > MaxSetBits) ? MaxSetBits : int'(set_bits_reg);
  endfunction

  function automatic int eff_ways();
    if (ways_reg == 4'd0) begin
      return 1;
    end
    return (ways_reg > Ways) ? Ways : int'(ways_reg);
  endfunction

  // Look up one address, update the line store and return the outcome.
  function automatic logic [1:0] touch_line(input logic [63:0] addr);
    int          s;
    int          b;
    int          e;
    int          w;
    int          base;
    int          hit_way;
    int          empty_way;
    int          old_way;
    int          place;
    logic [63:0] set_idx;
    logic [63:0] tag;
    logic [63:0] old_stamp;
    logic [1:0]  outcome;
    s         = eff_set_bits();
    b         = int'(offset_bits_reg);
    e         = eff_ways();
    set_idx   = (addr >> b) & ((64'd1 << s) - 64'd1);
    tag       = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
    base      = int'(set_idx) * Ways;
    hit_way   = -1;
    empty_way = -1;
    old_way   = -1;
    old_stamp = '0;
    for (w = 0; w < e; w++) begin
      if (hit_way < 0) begin
        if (line_valid[base + w]) begin
          if (line_tag[base + w] == tag) begin
            hit_way = w;
          end else if (old_way < 0 || line_stamp[base + w] < old_stamp) begin
            old_stamp = line_stamp[base + w];
            old_way   = w;
          end
        end else if (empty_way < 0) begin
          empty_way = w;
        end
      end
    end
    if (hit_way >= 0) begin
      hits_seen                   = sat_inc(hits_seen);
      line_stamp[base + hit_way]  = use_stamp;
      use_stamp                   = use_stamp + 64'd1;
      return OUT_HIT;
    end
    misses_seen = sat_inc(misses_seen);
    if (empty_way >= 0) begin
      place   = empty_way;
      outcome = OUT_MISS;
    end else begin
      evictions_seen = sat_inc(evictions_seen);
      place          = old_way;
      outcome        = OUT_EVICT;
    end
    line_valid[base + place] = 1'b1;
    line_tag[base + place]   = tag;
    line_stamp[base + place] = use_stamp;
    use_stamp                = use_stamp + 64'd1;
    return outcome;
  endfunction

  task automatic predict_access(input logic [1:0] op, input logic [63:0] addr);
    int   count;
    int   k;
    out_t r;
    count = (op == OP_MODIFY) ? 2 : 1;
    for (k = 0; k < count; k++) begin
      r.outcome        = touch_line(addr);
      r.last_of_run    = (k == count - 1);
      r.hit_total      = hits_seen;
      r.miss_total     = misses_seen;
      r.eviction_total = evictions_seen;
      expected_results.push_back(r);
    end
  endtask

  // Called and returns at a falling edge.
  task automatic send_access(input logic [1:0] op, input logic [63:0] addr);
    logic taken;
    taken = 1'b0;
    if (!steady) begin
      while ($urandom_range(99) < 24) @(negedge clk_i);
    end
    in_data_i.operation = op;
    in_data_i.address   = addr;
    in_valid_i          = 1'b1;
    while (!taken) begin
      @(posedge clk_i);
      if (in_ready_o) begin
        taken = 1'b1;
        predict_access(op, addr);
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    logic taken;
    taken       = 1'b0;
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    while (!taken) begin
      @(posedge clk_i);
      if (cfg_ready_o) begin
        taken = 1'b1;
        case (idx)
          CFG_SET_BITS:    set_bits_reg    = data[2:0];
          CFG_OFFSET_BITS: offset_bits_reg = data[5:0];
          CFG_WAYS:        ways_reg        = data[3:0];
          default: ;
        endcase
      end
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Unused upper data bits are randomized to check the register masks.
  task automatic apply_config(input logic [2:0] s, input logic [5:0] b,
                              input logic [3:0] w);
    logic [CfgDataW-1:0] d;
    wait_drained();
    d      = CfgDataW'($urandom);
    d[2:0] = s;
    write_register(CFG_SET_BITS, d);
    write_register(CFG_OFFSET_BITS, b);
    d      = CfgDataW'($urandom);
    d[3:0] = w;
    write_register(CFG_WAYS, d);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic test_reset_settings();
    send_access(OP_LOAD, 64'h0);
    send_access(OP_LOAD, 64'h0);
    send_access(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(OP_MODIFY, 64'h8000_0000_0000_0001);
    send_access(OpReserved, 64'h8000_0000_0000_0001);
    send_access(OP_LOAD, 64'h5555_5555_5555_5555);
    send_access(OP_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  task automatic test_clamp_and_wide_split();
    apply_config(3'd7, 6'd63, 4'd0);
    write_register(CfgUnused, 6'h3F);
    send_access(OP_LOAD, 64'h0);
    send_access(OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
    send_access(OP_STORE, 64'h8000_0000_0000_0000);
    apply_config(3'd6, 6'd58, 4'd8);
    send_access(OP_MODIFY, 64'hFC00_0000_0000_0000);
    send_access(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_lru_victim();
    int k;
    apply_config(3'd2, 6'd3, 4'd8);
    for (k = 0; k < 8; k++) begin
      send_access(OP_LOAD, (64'(k) << 5) | 64'($urandom_range(7)));
    end
    send_access(OP_LOAD, 64'h0);
    send_access(OP_STORE, 64'(8) << 5);
    send_access(OP_LOAD, 64'(1) << 5);
  endtask

  task automatic test_random_traffic();
    logic [63:0] tag_pool [TagPoolMax];
    logic [63:0] addr;
    logic [63:0] set_sel;
    logic [1:0]  op;
    logic [2:0]  s;
    logic [5:0]  b;
    logic [3:0]  w;
    int          phase;
    int          n;
    int          k;
    int          pool_size;
    int          set_count;
    int          split;
    int          r;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin s = 3'd0; b = 6'd0;  w = 4'd1;  end
        1: begin s = 3'd6; b = 6'd58; w = 4'd8;  end
        2: begin s = 3'd3; b = 6'd4;  w = 4'd15; end
        4: begin s = 3'd1; b = 6'd2;  w = 4'd2;  end
        6: begin s = 3'd7; b = 6'd63; w = 4'd15; end
        default: begin
          s = 3'($urandom_range(7));
          b = 6'($urandom_range(63));
          w = 4'($urandom_range(15));
        end
      endcase
      apply_config(s, b, w);
      steady    = (phase == 4);
      pool_size = $urandom_range(1, TagPoolMax);
      for (k = 0; k < TagPoolMax; k++) begin
        tag_pool[k] = {$urandom, $urandom};
      end
      for (n = 0; n < PhaseItems; n++) begin
        r = $urandom_range(99);
        if (r < 5) begin
          op = OpReserved;
        end else if (r < 35) begin
          op = OP_LOAD;
        end else if (r < 65) begin
          op = OP_STORE;
        end else begin
          op = OP_MODIFY;
        end
        if ($urandom_range(99) < 20) begin
          addr = {$urandom, $urandom};
        end else begin
          set_count = 1 << eff_set_bits();
          if (set_count > 4 && $urandom_range(3) != 0) begin
            set_count = 4;
          end
          set_sel = 64'($urandom_range(set_count - 1));
          split   = eff_set_bits() + int'(offset_bits_reg);
          addr    = {$urandom, $urandom} & ((64'd1 << offset_bits_reg) - 64'd1);
          addr    = addr | (set_sel << offset_bits_reg);
          if (split < 64) begin
            addr = addr | (tag_pool[$urandom_range(pool_size - 1)] << split);
          end
        end
        send_access(op, addr);
      end
      steady = 1'b0;
    end
  endtask

  always @(negedge clk_i) begin
    if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        oldest_expected = expected_results.pop_front();
        check_field("outcome", oldest_expected.outcome, out_data_o.outcome);
        check_field("last_of_run", oldest_expected.last_of_run, out_data_o.last_of_run);
        check_field("hit_total", oldest_expected.hit_total, out_data_o.hit_total);
        check_field("miss_total", oldest_expected.miss_total, out_data_o.miss_total);
        check_field("eviction_total", oldest_expected.eviction_total,
                    out_data_o.eviction_total);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < LineCount; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_stamp[i] = '0;
    end
    use_stamp       = 64'd1;
    hits_seen       = '0;
    misses_seen     = '0;
    evictions_seen  = '0;
    set_bits_reg    = 3'd0;
    offset_bits_reg = 6'd0;
    ways_reg        = 4'd1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_settings();
    test_clamp_and_wide_split();
    test_lru_victim();
    test_random_traffic();
    wait_drained();
    repeat (16) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sacl_pkg.sv
design/sacl_fifo.sv
design/sacl_front.sv
design/sacl_back.sv
design/set_assoc_lru_cache_sim.sv
tb/set_assoc_lru_cache_sim_tb.sv
